>>> hdl/rbp_pkg.sv
package rbp_pkg;

  typedef enum logic [1:0] {
    KindEntry    = 2'd0,
    KindFinish   = 2'd1,
    KindOverflow = 2'd2
  } rbp_kind_e;

  localparam logic [1:0] RegDirBytes   = 2'd0;
  localparam logic [1:0] RegEntryLimit = 2'd1;

  localparam logic [3:0] TypeHighLow = 4'd3;
  localparam logic [3:0] TypeDir64   = 4'd10;

  localparam logic [31:0] HeaderBytes  = 32'd8;
  localparam logic [15:0] LimitDefault = 16'd4096;

  typedef struct packed {
    rbp_kind_e   kind;
    logic [31:0] target_rva;
    logic [3:0]  entry_type;
    logic [15:0] entry_count;
    logic        last;
  } rbp_result_t;

  typedef struct packed {
    logic [1:0]  num;
    rbp_result_t first;
    rbp_result_t second;
  } rbp_push_t;

endpackage

>>> hdl/pe_base_reloc_stream_parser.sv
// Channel  Direction  Handshake                      Payload
// s_axis   in         s_axis_tvalid / s_axis_tready  tdata[7:0] data_byte
// m_axis   out        m_axis_tvalid / m_axis_tready  tdata rva, type, count; tuser kind; tlast
// cfg      in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Bytes are parsed in the cycle they are accepted, one per cycle while the queue has room.
// Results pass through a four-word queue; a byte is accepted while room for two remains.
// A byte may produce up to two words, which then drain one per cycle while tready is high.
// Reset clears the parse state, sets the entry limit to 4096 and the directory length to 0.
// The configuration port is always ready.
module pe_base_reloc_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // target_rva, entry_type, entry_count, zero fill
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import rbp_pkg::*;

  logic [31:0] dir_bytes_q;
  logic [15:0] entry_limit_q;
  logic        step;
  rbp_push_t   push;
  rbp_result_t rslt;

  assign cfg_ready_o = 1'b1;
  assign step        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_bytes_q   <= '0;
      entry_limit_q <= LimitDefault;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegDirBytes:   dir_bytes_q   <= cfg_data_i;
        RegEntryLimit: entry_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rbp_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (s_axis_tdata),
    .dir_bytes_i   (dir_bytes_q),
    .entry_limit_i (entry_limit_q),
    .push_o        (push)
  );

  rbp_rslt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (rslt)
  );

  assign m_axis_tdata = {4'd0, rslt.entry_count, rslt.entry_type, rslt.target_rva};
  assign m_axis_tuser = rslt.kind;
  assign m_axis_tlast = rslt.last;

endmodule

>>> hdl/rbp_parse.sv
module rbp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic [31:0]        dir_bytes_i,
  input  logic [15:0]        entry_limit_i,
  output rbp_pkg::rbp_push_t push_o
);
  import rbp_pkg::*;

  logic [31:0] pos_q, pos_d, off_q, off_d, bs_q, bs_d;
  logic [31:0] page_q, page_d, len_q, len_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] cnt_q, cnt_d;
  logic        stop_q, stop_d, ovf_q, ovf_d;

  logic        in_range, hdr_short, type_ok, entry_hit, overflow, finish;
  logic [31:0] len_new, rel, span, rva;
  logic [32:0] block_end;
  rbp_result_t res_entry, res_ovf, res_fin;

  always_comb begin
    in_range  = !ovf_q && (pos_q < dir_bytes_i);
    hdr_short = (off_q == '0) && (({1'b0, bs_q} + 33'd8) > {1'b0, dir_bytes_i});
    len_new   = {byte_i, len_q[23:0]};
    block_end = {1'b0, bs_q} + {1'b0, len_new};
    rel       = off_q - HeaderBytes;
    span      = {len_q[31:1] - 31'd4, 1'b0};
    type_ok   = (byte_i[7:4] == TypeHighLow) || (byte_i[7:4] == TypeDir64);
    rva       = page_q + {20'd0, byte_i[3:0], hold_q};

    pos_d     = pos_q;
    off_d     = off_q;
    bs_d      = bs_q;
    page_d    = page_q;
    len_d     = len_q;
    hold_d    = hold_q;
    cnt_d     = cnt_q;
    stop_d    = stop_q;
    ovf_d     = ovf_q;
    entry_hit = 1'b0;
    overflow  = 1'b0;
    finish    = 1'b0;

    if (step_i) begin
      if (pos_q != '1) begin
        pos_d = pos_q + 32'd1;
        off_d = off_q + 32'd1;
      end
      if (in_range && !stop_q) begin
        if (hdr_short) begin
          stop_d = 1'b1;
        end else begin
          if (off_q < 32'd4) begin
            unique case (off_q[1:0])
              2'd0: page_d = {24'd0, byte_i};
              2'd1: page_d[15:8] = byte_i;
              2'd2: page_d[23:16] = byte_i;
              default: page_d[31:24] = byte_i;
            endcase
          end else if (off_q < HeaderBytes) begin
            unique case (off_q[1:0])
              2'd0: len_d = {24'd0, byte_i};
              2'd1: len_d[15:8] = byte_i;
              2'd2: len_d[23:16] = byte_i;
              default: begin
                len_d = len_new;
                if (len_new < HeaderBytes || block_end > {1'b0, dir_bytes_i}) begin
                  stop_d = 1'b1;
                end
              end
            endcase
          end else if (rel < span) begin
            if (!off_q[0]) begin
              hold_d = byte_i;
            end else if (type_ok) begin
              if (cnt_q >= entry_limit_i) begin
                ovf_d    = 1'b1;
                overflow = 1'b1;
              end else begin
                cnt_d     = cnt_q + 16'd1;
                entry_hit = 1'b1;
              end
            end
          end
          if (!stop_d && !overflow && off_q >= 32'd7 && (off_q + 32'd1) == len_d) begin
            bs_d  = pos_q + 32'd1;
            off_d = '0;
          end
        end
      end
      finish = in_range && !overflow && (pos_q == dir_bytes_i - 32'd1);
    end

    res_entry = '{kind: KindEntry, target_rva: rva, entry_type: byte_i[7:4],
                  entry_count: cnt_d, last: 1'b0};
    res_ovf   = '{kind: KindOverflow, target_rva: '0, entry_type: '0,
                  entry_count: cnt_q, last: 1'b1};
    res_fin   = '{kind: KindFinish, target_rva: '0, entry_type: '0,
                  entry_count: cnt_d, last: 1'b1};

    push_o.second = res_fin;
    push_o.first  = overflow ? res_ovf : (entry_hit ? res_entry : res_fin);
    push_o.num    = {1'b0, entry_hit | overflow} + {1'b0, finish};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      off_q  <= '0;
      bs_q   <= '0;
      page_q <= '0;
      len_q  <= '0;
      hold_q <= '0;
      cnt_q  <= '0;
      stop_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      off_q  <= off_d;
      bs_q   <= bs_d;
      page_q <= page_d;
      len_q  <= len_d;
      hold_q <= hold_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
      ovf_q  <= ovf_d;
    end
  end

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni) ovf_q |=> ovf_q)
    else $error("overflow flag cleared");
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni) stop_q |=> stop_q)
    else $error("stop flag cleared");
  a_ovf_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> push_o.num == 2'd0)
    else $error("result after overflow");

endmodule

>>> hdl/rbp_rslt_fifo.sv
module rbp_rslt_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rbp_pkg::rbp_push_t   push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rbp_pkg::rbp_result_t data_o
);
  import rbp_pkg::*;

  rbp_result_t mem_q [4];
  logic [1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        pop;

  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = wr_q + push_i.num;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_i.num} - {2'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue count out of range");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> cnt_q <= 3'd2)
    else $error("push without room");
  a_push_num: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i.num != 2'd3)
    else $error("more than two results pushed");

endmodule
